// ----- hw/rtl/auto_exposure_bisection_search_macros.svh -----
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef AUTO_EXPOSURE_BISECTION_SEARCH_MACROS_SVH
`define AUTO_EXPOSURE_BISECTION_SEARCH_MACROS_SVH

// same-cycle implication
`define AEBS_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("auto exposure assertion failed");

// next-cycle implication
`define AEBS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("auto exposure assertion failed");

`endif

// ----- hw/rtl/aebs_pkg.sv -----
package aebs_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int TARGET_W    = 16;
    localparam int FRAMES_W    = 7;
    localparam int EXP_CFG_W   = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_GOAL        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_TO_AVERAGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE_MIN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE_MAX      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE_STEP     = 3'd4;

    // reset values of the registers
    localparam logic [TARGET_W-1:0]  RST_LEVEL_GOAL    = 16'd52429;
    localparam logic [FRAMES_W-1:0]  RST_FRAMES        = 7'd1;
    localparam logic [EXP_CFG_W-1:0] RST_EXPOSURE_MIN  = 24'd1;
    localparam logic [EXP_CFG_W-1:0] RST_EXPOSURE_MAX  = 24'd1000000;
    localparam logic [EXP_CFG_W-1:0] RST_EXPOSURE_STEP = 24'd1;

    // input command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // result status codes
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CONVERGED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic start;
        logic idle;
        logic accum;
        logic emit_run;
        logic mul;
        logic eval;
        logic tol;
        logic prep;
        logic step;
        logic emit_win;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic running;
        logic win_full;
    } dp_status_t;

endpackage

// ----- hw/rtl/aebs_cfg.sv -----
module aebs_cfg #(
    parameter int LEVEL_BITS    = 16,
    parameter int EXPOSURE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [aebs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [aebs_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [LEVEL_BITS-1:0]                 level_goal,
    output logic [aebs_pkg::FRAMES_W-1:0]         frames_to_average,
    output logic [EXPOSURE_BITS-1:0]              exposure_min,
    output logic [EXPOSURE_BITS-1:0]              exposure_max,
    output logic [EXPOSURE_BITS-1:0]              exposure_step
);

    logic [LEVEL_BITS-1:0]          target_reg, target_next;
    logic [aebs_pkg::FRAMES_W-1:0]  frames_reg, frames_next;
    logic [EXPOSURE_BITS-1:0]       emin_reg, emin_next;
    logic [EXPOSURE_BITS-1:0]       emax_reg, emax_next;
    logic [EXPOSURE_BITS-1:0]       estep_reg, estep_next;

    always_comb
    begin
        target_next = target_reg;
        frames_next = frames_reg;
        emin_next   = emin_reg;
        emax_next   = emax_reg;
        estep_next  = estep_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                aebs_pkg::CFG_LEVEL_GOAL:
                    target_next = LEVEL_BITS'(cfg_data[aebs_pkg::TARGET_W-1:0]);
                aebs_pkg::CFG_FRAMES_TO_AVERAGE:
                    frames_next = cfg_data[aebs_pkg::FRAMES_W-1:0];
                aebs_pkg::CFG_EXPOSURE_MIN:
                    emin_next = EXPOSURE_BITS'(cfg_data[aebs_pkg::EXP_CFG_W-1:0]);
                aebs_pkg::CFG_EXPOSURE_MAX:
                    emax_next = EXPOSURE_BITS'(cfg_data[aebs_pkg::EXP_CFG_W-1:0]);
                aebs_pkg::CFG_EXPOSURE_STEP:
                    estep_next = EXPOSURE_BITS'(cfg_data[aebs_pkg::EXP_CFG_W-1:0]);
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= LEVEL_BITS'(aebs_pkg::RST_LEVEL_GOAL);
            frames_reg <= aebs_pkg::RST_FRAMES;
            emin_reg   <= EXPOSURE_BITS'(aebs_pkg::RST_EXPOSURE_MIN);
            emax_reg   <= EXPOSURE_BITS'(aebs_pkg::RST_EXPOSURE_MAX);
            estep_reg  <= EXPOSURE_BITS'(aebs_pkg::RST_EXPOSURE_STEP);
        end
        else
        begin
            target_reg <= target_next;
            frames_reg <= frames_next;
            emin_reg   <= emin_next;
            emax_reg   <= emax_next;
            estep_reg  <= estep_next;
        end
    end

    assign level_goal        = target_reg;
    assign frames_to_average = frames_reg;
    assign exposure_min      = emin_reg;
    assign exposure_max      = emax_reg;
    assign exposure_step     = estep_reg;

endmodule

// ----- hw/rtl/aebs_ctrl.sv -----
module aebs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  aebs_pkg::dp_status_t dp_status,
    output aebs_pkg::dp_cmd_t    dp_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_EVAL   = 8'b0000_1000,
        S_TOL    = 8'b0001_0000,
        S_PREP   = 8'b0010_0000,
        S_STEP   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   emit;

    // result slot can take a new transaction this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        dp_cmd     = '0;
        emit       = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    if (dp_status.is_start)
                    begin
                        dp_cmd.start = 1'b1;
                        emit         = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (!dp_status.running)
                    begin
                        dp_cmd.idle = 1'b1;
                        emit        = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (dp_status.win_full)
                    begin
                        dp_cmd.accum = 1'b1;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        dp_cmd.accum    = 1'b1;
                        dp_cmd.emit_run = 1'b1;
                        emit            = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_MUL:
            begin
                dp_cmd.mul = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                dp_cmd.eval = 1'b1;
                state_next  = S_TOL;
            end
            S_TOL:
            begin
                dp_cmd.tol = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                dp_cmd.prep = 1'b1;
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                dp_cmd.step = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    dp_cmd.emit_win = 1'b1;
                    emit            = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/aebs_dp.sv -----
module aebs_dp #(
    parameter int LEVEL_BITS    = 16,
    parameter int EXPOSURE_BITS = 24,
    parameter int MAX_AVERAGE   = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  aebs_pkg::dp_cmd_t                  dp_cmd,
    output aebs_pkg::dp_status_t               dp_status,
    input  logic [LEVEL_BITS-1:0]              level_goal,
    input  logic [aebs_pkg::FRAMES_W-1:0]      frames_to_average,
    input  logic [EXPOSURE_BITS-1:0]           exposure_min,
    input  logic [EXPOSURE_BITS-1:0]           exposure_max,
    input  logic [EXPOSURE_BITS-1:0]           exposure_step,
    input  logic                               command,
    input  logic [LEVEL_BITS-1:0]              level,
    output logic [EXPOSURE_BITS-1:0]           exposure,
    output logic                               exposure_changed,
    output logic [aebs_pkg::STATUS_W-1:0]      status
);

    localparam int EW   = EXPOSURE_BITS;
    localparam int CNTW = $clog2(MAX_AVERAGE + 1);
    localparam int SUMW = LEVEL_BITS + $clog2(MAX_AVERAGE);
    localparam int PRDW = LEVEL_BITS + CNTW;
    localparam int TOLW = SUMW + 7;
    localparam int CMPW = (CNTW > aebs_pkg::FRAMES_W) ? CNTW : aebs_pkg::FRAMES_W;

    function automatic logic [EW-1:0] midpoint(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [EW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[EW:1];
    endfunction

    function automatic logic [EW-1:0] abs_diff(input logic [EW-1:0] a, input logic [EW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // transaction latch
    logic                  cmd_in_reg, cmd_in_next;
    logic [LEVEL_BITS-1:0] level_in_reg, level_in_next;

    // search state
    logic            running_reg, running_next;
    logic [EW-1:0]   cur_reg, cur_next;
    logic [EW-1:0]   lower_reg, lower_next;
    logic [EW-1:0]   upper_reg, upper_next;
    logic            br_reg, br_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    // evaluation pipeline of a full window
    logic [SUMW-1:0] tgt_reg, tgt_next;
    logic [SUMW-1:0] diff_reg, diff_next;
    logic            below_reg, below_next;
    logic            conv_reg, conv_next;
    logic [EW-1:0]   ref_reg, ref_next;
    logic            chk_reg, chk_next;
    logic            chg_reg, chg_next;
    logic            fin_reg, fin_next;
    logic [aebs_pkg::STATUS_W-1:0] st_reg, st_next;

    // result register
    logic [EW-1:0]                 exp_out_reg, exp_out_next;
    logic                          chg_out_reg, chg_out_next;
    logic [aebs_pkg::STATUS_W-1:0] st_out_reg, st_out_next;

    logic [EW-1:0]   eff_min;
    logic [CMPW-1:0] frames_w;
    logic [CMPW-1:0] eff_frames;
    logic [CNTW-1:0] cnt_inc;
    logic [PRDW-1:0] product;
    logic [TOLW-1:0] diff100;
    logic [TOLW-1:0] tol_bound;
    logic [EW:0]     doubled;
    logic [EW-1:0]   dbl;
    logic [EW-1:0]   lower_half;

    assign eff_min    = (exposure_min == '0) ? EW'(1) : exposure_min;
    assign frames_w   = CMPW'(frames_to_average);
    assign eff_frames = (frames_w == '0) ? CMPW'(1) :
                        ((frames_w > CMPW'(MAX_AVERAGE)) ? CMPW'(MAX_AVERAGE) : frames_w);
    assign cnt_inc    = cnt_reg + CNTW'(1);

    assign product    = PRDW'(level_goal) * PRDW'(cnt_reg);
    // times 100 as shifts
    assign diff100    = TOLW'({diff_reg, 6'b0}) + TOLW'({diff_reg, 5'b0})
                      + TOLW'({diff_reg, 2'b0});
    assign tol_bound  = TOLW'({cnt_reg, {LEVEL_BITS{1'b0}}});

    assign doubled    = {lower_reg, 1'b0};
    assign dbl        = (doubled > {1'b0, exposure_max}) ? exposure_max : doubled[EW-1:0];
    assign lower_half = lower_reg >> 1;

    always_comb
    begin
        cmd_in_next   = cmd_in_reg;
        level_in_next = level_in_reg;
        running_next  = running_reg;
        cur_next      = cur_reg;
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        br_next       = br_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        tgt_next      = tgt_reg;
        diff_next     = diff_reg;
        below_next    = below_reg;
        conv_next     = conv_reg;
        ref_next      = ref_reg;
        chk_next      = chk_reg;
        chg_next      = chg_reg;
        fin_next      = fin_reg;
        st_next       = st_reg;
        exp_out_next  = exp_out_reg;
        chg_out_next  = chg_out_reg;
        st_out_next   = st_out_reg;

        if (dp_cmd.load_in)
        begin
            cmd_in_next   = command;
            level_in_next = level;
        end

        if (dp_cmd.start)
        begin
            running_next = 1'b1;
            cur_next     = eff_min;
            lower_next   = eff_min;
            upper_next   = '0;
            br_next      = 1'b0;
            sum_next     = '0;
            cnt_next     = '0;
            exp_out_next = eff_min;
            chg_out_next = 1'b1;
            st_out_next  = aebs_pkg::ST_RUNNING;
        end

        if (dp_cmd.idle)
        begin
            exp_out_next = cur_reg;
            chg_out_next = 1'b0;
            st_out_next  = aebs_pkg::ST_IDLE;
        end

        if (dp_cmd.accum)
        begin
            sum_next = sum_reg + SUMW'(level_in_reg);
            cnt_next = cnt_inc;
        end

        if (dp_cmd.emit_run)
        begin
            exp_out_next = cur_reg;
            chg_out_next = 1'b0;
            st_out_next  = aebs_pkg::ST_RUNNING;
        end

        if (dp_cmd.mul)
            tgt_next = product[SUMW-1:0];

        if (dp_cmd.eval)
        begin
            diff_next  = (sum_reg >= tgt_reg) ? (sum_reg - tgt_reg) : (tgt_reg - sum_reg);
            below_next = (sum_reg < tgt_reg);
        end

        if (dp_cmd.tol)
            conv_next = (diff100 < tol_bound);

        if (dp_cmd.prep)
        begin
            chk_next = 1'b0;
            chg_next = 1'b0;
            fin_next = 1'b0;
            st_next  = aebs_pkg::ST_RUNNING;
            if (conv_reg)
            begin
                st_next  = aebs_pkg::ST_CONVERGED;
                fin_next = 1'b1;
            end
            else if (below_reg)
            begin
                if (!br_reg)
                begin
                    // still doubling toward a bracket
                    cur_next = dbl;
                    chg_next = 1'b1;
                    if (dbl >= exposure_max)
                    begin
                        st_next  = aebs_pkg::ST_UNDER;
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        lower_next = dbl;
                    end
                end
                else
                begin
                    lower_next = cur_reg;
                    cur_next   = midpoint(cur_reg, upper_reg);
                    ref_next   = cur_reg;
                    chk_next   = 1'b1;
                    chg_next   = 1'b1;
                end
            end
            else
            begin
                if (!br_reg)
                begin
                    if (cur_reg == eff_min)
                    begin
                        st_next  = aebs_pkg::ST_OVER;
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        // first overshoot sets the bracket
                        upper_next = lower_reg;
                        br_next    = 1'b1;
                        lower_next = lower_half;
                        cur_next   = midpoint(lower_half, lower_reg);
                        chg_next   = 1'b1;
                    end
                end
                else
                begin
                    upper_next = cur_reg;
                    cur_next   = midpoint(lower_reg, cur_reg);
                    ref_next   = cur_reg;
                    chk_next   = 1'b1;
                    chg_next   = 1'b1;
                end
            end
        end

        if (dp_cmd.step)
        begin
            if (chk_reg && (abs_diff(ref_reg, cur_reg) <= exposure_step))
            begin
                st_next  = aebs_pkg::ST_CONVERGED;
                fin_next = 1'b1;
            end
        end

        if (dp_cmd.emit_win)
        begin
            exp_out_next = cur_reg;
            chg_out_next = chg_reg;
            st_out_next  = st_reg;
            sum_next     = '0;
            cnt_next     = '0;
            if (fin_reg)
                running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cur_reg     <= '0;
            lower_reg   <= '0;
            upper_reg   <= '0;
            br_reg      <= 1'b0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            cur_reg     <= cur_next;
            lower_reg   <= lower_next;
            upper_reg   <= upper_next;
            br_reg      <= br_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_in_reg   <= cmd_in_next;
        level_in_reg <= level_in_next;
        tgt_reg      <= tgt_next;
        diff_reg     <= diff_next;
        below_reg    <= below_next;
        conv_reg     <= conv_next;
        ref_reg      <= ref_next;
        chk_reg      <= chk_next;
        chg_reg      <= chg_next;
        fin_reg      <= fin_next;
        st_reg       <= st_next;
        exp_out_reg  <= exp_out_next;
        chg_out_reg  <= chg_out_next;
        st_out_reg   <= st_out_next;
    end

    assign dp_status.is_start = (cmd_in_reg == aebs_pkg::CMD_START);
    assign dp_status.running  = running_reg;
    assign dp_status.win_full = (CMPW'(cnt_inc) >= eff_frames);

    assign exposure         = exp_out_reg;
    assign exposure_changed = chg_out_reg;
    assign status           = st_out_reg;

endmodule

// ----- hw/rtl/auto_exposure_bisection_search.sv -----
// channel   handshake              payload
// in        in_valid / in_ready    command, level
// out       out_valid / out_ready  exposure, exposure_changed, status
// cfg       cfg_write              cfg_index, cfg_data
//
// a start, an idle sample or a sample inside a window: the transaction is latched, and its result is
// registered from the decide state once the result slot is free; in_ready stays low until idle again
// a sample that completes a window: result registered once the sequencer has passed through target
// multiply, difference, tolerance, bisection and step and the result slot is free
// reset clears the search and loads register defaults, no clearing pass
// a result not taken lets one more transaction in, which waits at its result stage, in_ready low
`include "auto_exposure_bisection_search_macros.svh"

module auto_exposure_bisection_search #(
    parameter int LEVEL_BITS    = 16,
    parameter int EXPOSURE_BITS = 24,
    parameter int MAX_AVERAGE   = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [LEVEL_BITS-1:0]             level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [EXPOSURE_BITS-1:0]          exposure,
    output logic                              exposure_changed,
    output logic [aebs_pkg::STATUS_W-1:0]     status,
    input  logic                              cfg_write,
    input  logic [aebs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [aebs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [LEVEL_BITS-1:0]         level_goal;
    logic [aebs_pkg::FRAMES_W-1:0] frames_to_average;
    logic [EXPOSURE_BITS-1:0]      exposure_min;
    logic [EXPOSURE_BITS-1:0]      exposure_max;
    logic [EXPOSURE_BITS-1:0]      exposure_step;
    aebs_pkg::dp_cmd_t             dp_cmd;
    aebs_pkg::dp_status_t          dp_status;
    logic                          result_load;
    logic                          start_shown;

    aebs_cfg #(
        .LEVEL_BITS    (LEVEL_BITS),
        .EXPOSURE_BITS (EXPOSURE_BITS)
    ) u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .level_goal        (level_goal),
        .frames_to_average (frames_to_average),
        .exposure_min      (exposure_min),
        .exposure_max      (exposure_max),
        .exposure_step     (exposure_step)
    );

    aebs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    aebs_dp #(
        .LEVEL_BITS    (LEVEL_BITS),
        .EXPOSURE_BITS (EXPOSURE_BITS),
        .MAX_AVERAGE   (MAX_AVERAGE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .dp_cmd            (dp_cmd),
        .dp_status         (dp_status),
        .level_goal        (level_goal),
        .frames_to_average (frames_to_average),
        .exposure_min      (exposure_min),
        .exposure_max      (exposure_max),
        .exposure_step     (exposure_step),
        .command           (command),
        .level             (level),
        .exposure          (exposure),
        .exposure_changed  (exposure_changed),
        .status            (status)
    );

    assign result_load = dp_cmd.start || dp_cmd.idle || dp_cmd.emit_run || dp_cmd.emit_win;
    assign start_shown = out_valid && exposure_changed && (status == aebs_pkg::ST_RUNNING);

    // one transaction in flight
    `AEBS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // a result is only written into a free slot
    `AEBS_ASSERT_NOW(a_emit_into_free_slot, result_load, !out_valid || out_ready)
    // a start always shows the new exposure
    `AEBS_ASSERT_NEXT(a_start_result, dp_cmd.start, start_shown)
    // overexposed leaves the exposure alone
    `AEBS_ASSERT_NOW(a_over_unchanged, out_valid && (status == aebs_pkg::ST_OVER), !exposure_changed)

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

    localparam int LEVEL_W         = 16;
    localparam int EXP_W           = 24;
    localparam int MAX_AVERAGE     = 64;
    localparam int HALF_PERIOD     = 10;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 83;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [EXP_W-1:0]              exposure;
        logic                          changed;
        logic [aebs_pkg::STATUS_W-1:0] status;
    } exposure_result_t;

    class exposure_search_scoreboard;
        logic [aebs_pkg::TARGET_W-1:0]  level_goal;
        logic [aebs_pkg::FRAMES_W-1:0]  frames_to_average;
        logic [aebs_pkg::EXP_CFG_W-1:0] exposure_min;
        logic [aebs_pkg::EXP_CFG_W-1:0] exposure_max;
        logic [aebs_pkg::EXP_CFG_W-1:0] exposure_step;

        bit               running;
        bit               bracketed;
        logic [EXP_W-1:0] cur_exposure;
        logic [EXP_W-1:0] lower_bound;
        logic [EXP_W-1:0] upper_bound;
        logic [21:0]      level_total;
        logic [6:0]       sample_count;

        exposure_result_t expected_results[$];
        int mismatches;
        int results_checked;
        int n_converged;
        int n_under;
        int n_over;
        int n_idle;

        function new();
            level_goal        = aebs_pkg::RST_LEVEL_GOAL;
            frames_to_average = aebs_pkg::RST_FRAMES;
            exposure_min      = aebs_pkg::RST_EXPOSURE_MIN;
            exposure_max      = aebs_pkg::RST_EXPOSURE_MAX;
            exposure_step     = aebs_pkg::RST_EXPOSURE_STEP;
            running           = 1'b0;
            bracketed         = 1'b0;
            cur_exposure      = '0;
            lower_bound       = '0;
            upper_bound       = '0;
            level_total       = '0;
            sample_count      = '0;
        endfunction

        function void write_reg(logic [aebs_pkg::CFG_INDEX_W-1:0] idx,
                                logic [aebs_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                aebs_pkg::CFG_LEVEL_GOAL:
                    level_goal = val[aebs_pkg::TARGET_W-1:0];
                aebs_pkg::CFG_FRAMES_TO_AVERAGE:
                    frames_to_average = val[aebs_pkg::FRAMES_W-1:0];
                aebs_pkg::CFG_EXPOSURE_MIN:
                    exposure_min = val[aebs_pkg::EXP_CFG_W-1:0];
                aebs_pkg::CFG_EXPOSURE_MAX:
                    exposure_max = val[aebs_pkg::EXP_CFG_W-1:0];
                aebs_pkg::CFG_EXPOSURE_STEP:
                    exposure_step = val[aebs_pkg::EXP_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned spread(longint unsigned a, longint unsigned b);
            return (a >= b) ? a - b : b - a;
        endfunction

        // one accepted transaction in, one expected result queued
        function void predict_exposure(logic cmd, logic [LEVEL_W-1:0] lvl);
            exposure_result_t r;
            longint unsigned n, total, cnt, goal, diff, nxt, low, high, cur, floor_exp;
            bit done;
            low       = 64'(lower_bound);
            high      = 64'(upper_bound);
            cur       = 64'(cur_exposure);
            floor_exp = (exposure_min == '0) ? 64'd1 : 64'(exposure_min);
            done      = 1'b0;
            r.changed = 1'b0;
            r.status  = aebs_pkg::ST_RUNNING;
            if (cmd == aebs_pkg::CMD_START)
            begin
                cur          = floor_exp;
                low          = cur;
                high         = 64'd0;
                bracketed    = 1'b0;
                level_total  = '0;
                sample_count = '0;
                running      = 1'b1;
                r.changed    = 1'b1;
            end
            else if (!running)
            begin
                r.status = aebs_pkg::ST_IDLE;
            end
            else
            begin
                n = 64'(frames_to_average);
                if (n == 64'd0)
                    n = 64'd1;
                else if (n > 64'(MAX_AVERAGE))
                    n = 64'(MAX_AVERAGE);
                total        = 64'(level_total) + 64'(lvl);
                cnt          = 64'(sample_count) + 64'd1;
                level_total  = total[21:0];
                sample_count = cnt[6:0];
                if (cnt >= n)
                begin
                    goal = 64'(level_goal) * cnt;
                    diff = spread(total, goal);
                    // average within 0.01 of full scale (65536) of the target, no rounding
                    if (diff * 64'd100 < (cnt << LEVEL_W))
                    begin
                        r.status = aebs_pkg::ST_CONVERGED;
                        done     = 1'b1;
                    end
                    else if (total < goal)
                    begin
                        if (!bracketed)
                        begin
                            nxt = low * 64'd2;
                            if (nxt > 64'(exposure_max))
                                nxt = 64'(exposure_max);
                            cur       = nxt;
                            r.changed = 1'b1;
                            if (cur >= 64'(exposure_max))
                            begin
                                r.status = aebs_pkg::ST_UNDER;
                                done     = 1'b1;
                            end
                            else
                            begin
                                low = cur;
                            end
                        end
                        else
                        begin
                            low       = cur;
                            cur       = (low + high) >> 1;
                            r.changed = 1'b1;
                            if (spread(low, cur) <= 64'(exposure_step))
                            begin
                                r.status = aebs_pkg::ST_CONVERGED;
                                done     = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (!bracketed)
                        begin
                            if (cur == floor_exp)
                            begin
                                r.status = aebs_pkg::ST_OVER;
                                done     = 1'b1;
                            end
                            else
                            begin
                                high      = low;
                                bracketed = 1'b1;
                                low       = low >> 1;
                                cur       = (low + high) >> 1;
                                r.changed = 1'b1;
                            end
                        end
                        else
                        begin
                            high      = cur;
                            cur       = (low + high) >> 1;
                            r.changed = 1'b1;
                            if (spread(high, cur) <= 64'(exposure_step))
                            begin
                                r.status = aebs_pkg::ST_CONVERGED;
                                done     = 1'b1;
                            end
                        end
                    end
                    level_total  = '0;
                    sample_count = '0;
                    if (done)
                        running = 1'b0;
                end
            end
            cur_exposure = cur[EXP_W-1:0];
            lower_bound  = low[EXP_W-1:0];
            upper_bound  = high[EXP_W-1:0];
            r.exposure   = cur_exposure;
            case (r.status)
                aebs_pkg::ST_CONVERGED: n_converged++;
                aebs_pkg::ST_UNDER:     n_under++;
                aebs_pkg::ST_OVER:      n_over++;
                aebs_pkg::ST_IDLE:      n_idle++;
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_exposure_result(logic [EXP_W-1:0] e, logic c,
                                            logic [aebs_pkg::STATUS_W-1:0] s);
            exposure_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: exposure %0d changed %0d status %0d",
                             e, c, s);
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (e !== want.exposure || c !== want.changed || s !== want.status)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d mismatch: expected exposure %0d changed %0d",
                              " status %0d, got exposure %0d changed %0d status %0d"},
                             results_checked, want.exposure, want.changed, want.status,
                             e, c, s);
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic                             command;
    logic [LEVEL_W-1:0]               level;
    logic                             out_valid;
    logic                             out_ready;
    logic [EXP_W-1:0]                 exposure;
    logic                             exposure_changed;
    logic [aebs_pkg::STATUS_W-1:0]    status;
    logic                             cfg_write;
    logic [aebs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [aebs_pkg::CFG_DATA_W-1:0]  cfg_data;

    exposure_search_scoreboard sb = new();

    bit              feed_gaps;
    bit              stall_on;
    bit              hold_request;
    int              n_sent;
    int              n_settings;
    longint unsigned scene_gain;

    auto_exposure_bisection_search dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .level            (level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .exposure         (exposure),
        .exposure_changed (exposure_changed),
        .status           (status),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        #(2 * HALF_PERIOD * 600000);
        $display("timeout with %0d results outstanding", sb.expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_exposure_result(exposure, exposure_changed, status);
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = stall_on ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    task automatic send_item(input logic cmd, input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        level    <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.predict_exposure(cmd, lvl);
        n_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [aebs_pkg::TARGET_W-1:0] tgt,
                             input logic [aebs_pkg::FRAMES_W-1:0] frames,
                             input logic [aebs_pkg::EXP_CFG_W-1:0] mn,
                             input logic [aebs_pkg::EXP_CFG_W-1:0] mx,
                             input logic [aebs_pkg::EXP_CFG_W-1:0] stp);
        logic [aebs_pkg::CFG_DATA_W-1:0]  vals[5];
        logic [aebs_pkg::CFG_INDEX_W-1:0] idx[5];
        settle();
        idx[0] = aebs_pkg::CFG_LEVEL_GOAL;
        vals[0] = aebs_pkg::CFG_DATA_W'(tgt);
        idx[1] = aebs_pkg::CFG_FRAMES_TO_AVERAGE;
        vals[1] = aebs_pkg::CFG_DATA_W'(frames);
        idx[2] = aebs_pkg::CFG_EXPOSURE_MIN;
        vals[2] = mn;
        idx[3] = aebs_pkg::CFG_EXPOSURE_MAX;
        vals[3] = mx;
        idx[4] = aebs_pkg::CFG_EXPOSURE_STEP;
        vals[4] = stp;
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    // brightness of a simple scene: proportional to exposure, plus a little noise
    function automatic logic [LEVEL_W-1:0] scene_level();
        longint unsigned v;
        v = (64'(sb.cur_exposure) * scene_gain) >> 20;
        if (v > 64'd65535)
            v = 64'd65535;
        v = v + 64'($urandom_range(0, 400));
        v = (v >= 64'd200) ? v - 64'd200 : 64'd0;
        if (v > 64'd65535)
            v = 64'd65535;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic longint unsigned new_scene_gain();
        return ({32'd0, $urandom()} >> $urandom_range(0, 31)) + 64'd1;
    endfunction

    initial
    begin
        int pick;
        in_valid     <= 1'b0;
        command      <= aebs_pkg::CMD_SAMPLE;
        level        <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        feed_gaps    = 1'b1;
        stall_on     = 1'b1;
        hold_request = 1'b0;
        n_sent       = 0;
        n_settings   = 1;
        scene_gain   = 64'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: idle samples, overexposed at minimum, then a full short search
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'hFFFF);
        send_item(aebs_pkg::CMD_START, 16'h5A5A);
        send_item(aebs_pkg::CMD_SAMPLE, 16'hFFFF);
        send_item(aebs_pkg::CMD_START, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'hFFFF);
        send_item(aebs_pkg::CMD_SAMPLE, 16'd52429);

        // doubling hits the maximum
        configure(16'd52429, 7'd1, 24'd1, 24'd3, 24'hFFFFFF);
        send_item(aebs_pkg::CMD_START, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);

        // bisection stops on a coarse step
        configure(16'd52429, 7'd1, 24'd1, 24'hFFFFFF, 24'hFFFFFF);
        send_item(aebs_pkg::CMD_START, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'hFFFF);
        send_item(aebs_pkg::CMD_SAMPLE, 16'hFFFF);

        // zero minimum acts as one
        configure(16'd52429, 7'd1, 24'd0, 24'd3, 24'd1);
        send_item(aebs_pkg::CMD_START, 16'h0000);

        // maximum below minimum
        configure(16'd52429, 7'd1, 24'hFFFFFF, 24'd3, 24'd1);
        send_item(aebs_pkg::CMD_START, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);

        // window shortened while partly filled completes on the next sample
        configure(16'd52429, 7'd4, 24'd1, 24'd1000000, 24'd1);
        send_item(aebs_pkg::CMD_START, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);
        configure(16'd52429, 7'd2, 24'd1, 24'd1000000, 24'd1);
        send_item(aebs_pkg::CMD_SAMPLE, 16'h0000);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure(16'd52429, 7'd1, 24'd1, 24'd1000000, 24'd1);
                1: configure(16'd0, 7'd0, 24'd0, 24'hFFFFFF, 24'd0);
                2: configure(16'hFFFF, 7'd127, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
                3: configure(16'hFFFF, 7'd64, 24'd1, 24'hFFFFFF, 24'd0);
                default:
                begin
                    configure(aebs_pkg::TARGET_W'($urandom_range(0, 65535)),
                              aebs_pkg::FRAMES_W'(($urandom_range(0, 9) < 8)
                                                  ? $urandom_range(1, 4)
                                                  : $urandom_range(0, 127)),
                              aebs_pkg::EXP_CFG_W'(($urandom_range(0, 9) < 8)
                                                   ? $urandom_range(0, 16)
                                                   : $urandom_range(0, 24'hFFFFFF)),
                              aebs_pkg::EXP_CFG_W'(($urandom_range(0, 9) < 8)
                                                   ? $urandom_range(1000, 24'hFFFFFF)
                                                   : $urandom_range(1, 64)),
                              aebs_pkg::EXP_CFG_W'(($urandom_range(0, 9) < 7)
                                                   ? $urandom_range(0, 4)
                                                   : $urandom_range(0, 24'hFFFFFF)));
                end
            endcase
            feed_gaps = (p % 3 != 1);
            stall_on  = (p % 3 != 1);
            // block fills up behind a long result hold-off
            if (p == 4)
                hold_request = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                begin
                    scene_gain = new_scene_gain();
                    send_item(aebs_pkg::CMD_START, LEVEL_W'($urandom_range(0, 65535)));
                end
                else if (pick < 12)
                begin
                    send_item(aebs_pkg::CMD_SAMPLE, LEVEL_W'($urandom_range(0, 65535)));
                end
                else if (!sb.running)
                begin
                    scene_gain = new_scene_gain();
                    send_item(aebs_pkg::CMD_START, LEVEL_W'($urandom_range(0, 65535)));
                end
                else
                begin
                    send_item(aebs_pkg::CMD_SAMPLE, scene_level());
                end
            end
        end

        settle();
        $display("sent %0d transactions, checked %0d results over %0d register settings",
                 n_sent, sb.results_checked, n_settings);
        $display("searches ended: %0d converged, %0d underexposed, %0d overexposed",
                 sb.n_converged, sb.n_under, sb.n_over);
        $display("samples ignored while idle: %0d", sb.n_idle);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
